// ===== rtl/core/wildcard_automaton_matcher_macros.svh =====
// Assertion macros used by the matcher back end.
`ifndef WILDCARD_AUTOMATON_MATCHER_MACROS_SVH
`define WILDCARD_AUTOMATON_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define WAM_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
`define WAM_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`else
`define WAM_ASSERT_IMP(lbl, clk, rstn, a, c, msg)
`define WAM_ASSERT_NXT(lbl, clk, rstn, a, c, msg)
`endif
`endif

// ===== rtl/core/wam_pkg.sv =====
// Shared types and codes of the wildcard automaton matcher.
package wam_pkg;
	localparam logic [1:0] CMD_CHAR = 2'd0;
	localparam logic [1:0] CMD_EDGE = 2'd1;
	localparam logic [1:0] CMD_HDR  = 2'd2;

	localparam logic REG_STEP_COUNT = 1'b0;
	localparam logic REG_MAX_BYTES  = 1'b1;

	localparam logic [1:0] CAUSE_END    = 2'd0;
	localparam logic [1:0] CAUSE_TERM   = 2'd1;
	localparam logic [1:0] CAUSE_NOEDGE = 2'd2;
	localparam logic [1:0] CAUSE_LIMIT  = 2'd3;

	typedef enum logic [1:0] {KIND_NONE, KIND_CHAR, KIND_EDGE, KIND_HDR} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        first_char;
		logic [20:0] codepoint;
		logic [2:0]  byte_len;
		logic [7:0]  step_index;
		logic [3:0]  slot;
		logic [8:0]  edge_target;
		logic [3:0]  edge_total;
		logic [7:0]  other_target;
		logic        other_valid;
	} item_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] cause;
	} res_t;
endpackage

// ===== rtl/core/wildcard_automaton_matcher.sv =====
// Top level of the wildcard automaton matcher.
// Load beats (edge entries, step headers) go straight into the tables. A character beat
// reads its step header, then scans up to n edge entries, n being that step's edge count
// (at most MAX_EDGES); the edge table has one read port, scanned one entry per cycle.
// Early exits (repeat verdict, empty pattern, terminator, step out of range) skip it. A two-entry
// queue on each side lets the input and the result sides stall independently. The
// tables power up undefined and need no clearing; write a step before it is walked.
module wildcard_automaton_matcher #(
	parameter int MAX_STEPS = 256,
	parameter int MAX_EDGES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic        first_char,
	input  logic [20:0] codepoint,
	input  logic [2:0]  byte_len,
	input  logic [7:0]  step_index,
	input  logic [3:0]  slot,
	input  logic [8:0]  edge_target,
	input  logic [3:0]  edge_total,
	input  logic [7:0]  other_target,
	input  logic        other_valid,
	output logic        empty,
	input  logic        pop,
	output logic        matched,
	output logic [1:0]  cause,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data
);
	import wam_pkg::*;

	logic        item_valid;
	item_t       item;
	logic        item_pop;
	logic        res_push;
	res_t        res;
	logic        res_full;
	logic [8:0]  goal_step_q;
	logic [15:0] max_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_step_q <= 9'd0;
			max_bytes_q <= 16'd4096;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STEP_COUNT: goal_step_q <= wr_data[8:0];
				REG_MAX_BYTES:  max_bytes_q <= wr_data;
				default: ;
			endcase
		end
	end

	wam_front #(.MAX_STEPS(MAX_STEPS), .MAX_EDGES(MAX_EDGES)) u_front (
		.clk, .arst_n, .push, .full, .cmd, .first_char, .codepoint, .byte_len,
		.step_index, .slot, .edge_target, .edge_total, .other_target, .other_valid,
		.item_valid, .item, .item_pop
	);

	wam_back #(.MAX_STEPS(MAX_STEPS), .MAX_EDGES(MAX_EDGES)) u_back (
		.clk, .arst_n, .item_valid, .item, .item_pop,
		.goal_step(goal_step_q), .max_bytes(max_bytes_q),
		.res_push, .res, .res_full
	);

	wam_res_q u_res_q (
		.clk, .arst_n, .res_push, .res, .res_full, .empty, .pop, .matched, .cause
	);
endmodule

// ===== rtl/core/wam_front.sv =====
// Front: accepts input beats, classifies them and queues them for the back.
module wam_front #(
	parameter int MAX_STEPS = 256,
	parameter int MAX_EDGES = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    cmd,
	input  logic          first_char,
	input  logic [20:0]   codepoint,
	input  logic [2:0]    byte_len,
	input  logic [7:0]    step_index,
	input  logic [3:0]    slot,
	input  logic [8:0]    edge_target,
	input  logic [3:0]    edge_total,
	input  logic [7:0]    other_target,
	input  logic          other_valid,
	output logic          item_valid,
	output wam_pkg::item_t item,
	input  logic          item_pop
);
	import wam_pkg::*;

	item_t        buf_q [2];
	logic [1:0]   cnt_q;
	logic         wr_q;
	logic         rd_q;
	item_t        cls;
	logic         acc;

	always_comb begin
		cls.first_char   = first_char;
		cls.codepoint    = codepoint;
		cls.byte_len     = byte_len;
		cls.step_index   = step_index;
		cls.slot         = slot;
		cls.edge_target  = edge_target;
		cls.edge_total   = edge_total;
		cls.other_target = other_target;
		cls.other_valid  = other_valid;
		unique case (cmd)
			CMD_CHAR: cls.kind = KIND_CHAR;
			CMD_EDGE: cls.kind = (32'(step_index) < MAX_STEPS && 32'(slot) < MAX_EDGES)
				? KIND_EDGE : KIND_NONE;
			CMD_HDR:  cls.kind = (32'(step_index) < MAX_STEPS) ? KIND_HDR : KIND_NONE;
			default:  cls.kind = KIND_NONE;
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign acc        = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (acc) begin
				wr_q <= ~wr_q;
			end
			if (item_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(item_pop);
		end
	end
endmodule

// ===== rtl/core/wam_back.sv =====
// Back: holds the step tables and walks the automaton, scanning one edge entry per cycle.
module wam_back #(
	parameter int MAX_STEPS = 256,
	parameter int MAX_EDGES = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  wam_pkg::item_t item,
	output logic           item_pop,
	input  logic [8:0]     goal_step,
	input  logic [15:0]    max_bytes,
	output logic           res_push,
	output wam_pkg::res_t  res,
	input  logic           res_full
);
	import wam_pkg::*;
	`include "wildcard_automaton_matcher_macros.svh"

	localparam int DEPTH = MAX_STEPS * MAX_EDGES;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(MAX_STEPS);
	localparam int EW = $clog2(MAX_EDGES + 1);

	typedef enum logic [1:0] {S_IDLE, S_HDR, S_SCAN, S_FIN} state_t;

	typedef struct packed {
		logic [20:0] cp;
		logic [8:0]  tgt;
	} edge_t;

	typedef struct packed {
		logic [3:0] cnt;
		logic       fb_v;
		logic [7:0] fb_t;
	} hdr_t;

	edge_t   edge_mem [DEPTH];
	hdr_t    hdr_mem [MAX_STEPS];
	edge_t   edge_rd_q;
	hdr_t    hdr_rd_q;

	state_t      st_q;
	logic [8:0]  cur_step_q;
	logic [15:0] bytes_q;
	logic        verdict_q;
	logic [AW-1:0] base_q;
	logic [20:0] cp_q;
	logic [2:0]  blen_q;
	logic [EW-1:0] n_q;
	logic [EW-1:0] idx_q;
	logic        rdv_q;
	logic        fb_v_q;
	logic [7:0]  fb_t_q;
	logic [8:0]  next_q;

	logic        eff_verdict;
	logic [8:0]  eff_step;
	logic [15:0] eff_bytes;
	logic        is_char;
	logic        hdr_re;
	logic        edge_we;
	logic        hdr_we;
	logic        hit;
	logic        issue;
	logic [AW-1:0] edge_ra;
	logic [AW-1:0] edge_wa;
	logic [16:0] sum;
	logic [15:0] sat;
	logic [EW-1:0] n_clamp;

	always_comb begin
		is_char     = (item.kind == KIND_CHAR);
		item_pop    = (st_q == S_IDLE) && item_valid && (!is_char || !res_full);
		eff_verdict = item.first_char ? 1'b0 : verdict_q;
		eff_step    = item.first_char ? 9'd0 : cur_step_q;
		eff_bytes   = item.first_char ? 16'd0 : bytes_q;
		edge_we     = item_pop && (item.kind == KIND_EDGE);
		hdr_we      = item_pop && (item.kind == KIND_HDR);
		edge_wa     = AW'(item.step_index) * AW'(MAX_EDGES) + AW'(item.slot);
		hdr_re      = 1'b0;
		hit         = rdv_q && (edge_rd_q.cp == cp_q);
		issue       = (st_q == S_SCAN) && !hit && (idx_q < n_q);
		edge_ra     = base_q + AW'(idx_q);
		n_clamp     = (32'(hdr_rd_q.cnt) > MAX_EDGES) ? EW'(MAX_EDGES) : EW'(hdr_rd_q.cnt);
		sum         = {1'b0, bytes_q} + 17'(blen_q);
		sat         = sum[16] ? 16'hFFFF : sum[15:0];
		res_push    = 1'b0;
		res.matched = 1'b0;
		res.cause   = CAUSE_END;
		unique case (st_q)
			S_IDLE: begin
				if (item_pop && is_char && !eff_verdict) begin
					res_push = 1'b1;
					if (goal_step == 9'd0) begin
						res.matched = 1'b1;
					end else if (item.codepoint == 21'd0) begin
						res.cause = CAUSE_TERM;
					end else if (32'(eff_step) >= MAX_STEPS) begin
						res.cause = CAUSE_NOEDGE;
					end else begin
						res_push = 1'b0;
						hdr_re   = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (!hit && !issue && !fb_v_q) begin
					res_push  = 1'b1;
					res.cause = CAUSE_NOEDGE;
				end
			end
			S_FIN: begin
				if (next_q == goal_step) begin
					res_push    = 1'b1;
					res.matched = 1'b1;
				end else if (sat >= max_bytes) begin
					res_push  = 1'b1;
					res.cause = CAUSE_LIMIT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= '{cp: item.codepoint, tgt: item.edge_target};
		end
		if (issue) begin
			edge_rd_q <= edge_mem[edge_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[SW'(item.step_index)] <= '{cnt: item.edge_total, fb_v: item.other_valid,
				fb_t: item.other_target};
		end
		if (hdr_re) begin
			hdr_rd_q <= hdr_mem[SW'(eff_step)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			cur_step_q <= 9'd0;
			bytes_q    <= 16'd0;
			verdict_q  <= 1'b0;
			rdv_q      <= 1'b0;
			idx_q      <= '0;
			n_q        <= '0;
			base_q     <= '0;
			cp_q       <= '0;
			blen_q     <= '0;
			fb_v_q     <= 1'b0;
			fb_t_q     <= '0;
			next_q     <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (item_pop && is_char) begin
						cur_step_q <= eff_step;
						bytes_q    <= eff_bytes;
						verdict_q  <= eff_verdict | res_push;
						cp_q       <= item.codepoint;
						blen_q     <= item.byte_len;
						base_q     <= AW'(SW'(eff_step)) * AW'(MAX_EDGES);
						if (hdr_re) begin
							st_q <= S_HDR;
						end
					end
				end
				S_HDR: begin
					n_q    <= n_clamp;
					idx_q  <= '0;
					rdv_q  <= 1'b0;
					fb_v_q <= hdr_rd_q.fb_v;
					fb_t_q <= hdr_rd_q.fb_t;
					st_q   <= S_SCAN;
				end
				S_SCAN: begin
					rdv_q <= issue;
					if (hit) begin
						next_q <= edge_rd_q.tgt;
						st_q   <= S_FIN;
					end else if (issue) begin
						idx_q <= idx_q + EW'(1);
					end else if (fb_v_q) begin
						next_q <= {1'b0, fb_t_q};
						st_q   <= S_FIN;
					end else begin
						verdict_q <= 1'b1;
						st_q      <= S_IDLE;
					end
				end
				S_FIN: begin
					cur_step_q <= next_q;
					if (next_q != goal_step) begin
						bytes_q <= sat;
					end
					verdict_q <= res_push;
					st_q      <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`WAM_ASSERT_IMP(a_res_room, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`WAM_ASSERT_IMP(a_idx_bound, clk, arst_n, st_q == S_SCAN, idx_q <= n_q, "edge index past count")
	`WAM_ASSERT_NXT(a_hdr_next, clk, arst_n, hdr_re, st_q == S_HDR, "header read without wait")
	`WAM_ASSERT_IMP(a_pop_idle, clk, arst_n, item_pop, st_q == S_IDLE, "item taken while busy")
endmodule

// ===== rtl/core/wam_res_q.sv =====
// Result queue between the back and the output ports.
module wam_res_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  wam_pkg::res_t res,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output logic          matched,
	output logic [1:0]    cause
);
	import wam_pkg::*;

	res_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       take;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign take     = pop && !empty;
	assign matched  = buf_q[rd_q].matched;
	assign cause    = buf_q[rd_q].cause;

	always_ff @(posedge clk) begin
		if (res_push) begin
			buf_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (res_push) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(res_push) - 2'(take);
		end
	end
endmodule

// ===== verif/tb_wildcard_automaton_matcher.sv =====
// Self-checking testbench for the wildcard automaton matcher: loads step tables, streams strings, checks verdicts.
`timescale 1ns / 100ps

module tb_wildcard_automaton_matcher;
	import wam_pkg::*;

	localparam int          N_STEPS    = 256;
	localparam int          N_EDGES    = 12;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam int          CYCLE_LIMIT = 3000000;
	localparam int          DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  cmd;
	logic        first_char;
	logic [20:0] codepoint;
	logic [2:0]  byte_len;
	logic [7:0]  step_index;
	logic [3:0]  slot;
	logic [8:0]  edge_target;
	logic [3:0]  edge_total;
	logic [7:0]  other_target;
	logic        other_valid;
	logic        empty;
	logic        pop;
	logic        matched;
	logic [1:0]  cause;
	logic        wr_en;
	logic        wr_index;
	logic [15:0] wr_data;

	// predictor state
	logic [20:0] edge_cp_tab [N_STEPS][N_EDGES];
	logic [8:0]  edge_to_tab [N_STEPS][N_EDGES];
	logic [3:0]  edge_cnt_tab [N_STEPS];
	logic [8:0]  fallback_tab [N_STEPS];
	logic [8:0]  cur_step;
	int          bytes_seen;
	logic        verdict_done;
	logic [8:0]  goal_step;
	logic [15:0] max_bytes;

	res_t        verdict_q[$];
	int          errors;
	int          cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          pat_n;

	wildcard_automaton_matcher DUT (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// receiver: random pop, check at the falling edge before the accepting edge
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(negedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected verdict matched=%0d cause=%0d",
					matched, cause));
			end else begin
				want = verdict_q.pop_front();
				if (matched !== want.matched)
					flag_mismatch($sformatf("matched %0d, want %0d", matched, want.matched));
				if (cause !== want.cause)
					flag_mismatch($sformatf("cause %0d, want %0d", cause, want.cause));
			end
		end
	end

	task automatic give_verdict(input logic m, input logic [1:0] c);
		res_t r;
		r.matched = m;
		r.cause = c;
		verdict_q.push_back(r);
		verdict_done = 1'b1;
	endtask

	task automatic predict_verdict(input logic first, input logic [20:0] cp,
			input logic [2:0] blen);
		int   n;
		logic found;
		logic [8:0] nxt;
		if (first) begin
			cur_step = '0;
			bytes_seen = 0;
			verdict_done = 1'b0;
		end
		if (verdict_done)
			return;
		if (goal_step == 0) begin
			give_verdict(1'b1, CAUSE_END);
			return;
		end
		if (cp == 0) begin
			give_verdict(1'b0, CAUSE_TERM);
			return;
		end
		found = 1'b0;
		nxt = '0;
		if (cur_step < N_STEPS) begin
			n = edge_cnt_tab[cur_step];
			if (n > N_EDGES)
				n = N_EDGES;
			for (int i = 0; i < n && !found; i++) begin
				if (edge_cp_tab[cur_step][i] == cp) begin
					nxt = edge_to_tab[cur_step][i];
					found = 1'b1;
				end
			end
			if (!found && fallback_tab[cur_step][8]) begin
				nxt = {1'b0, fallback_tab[cur_step][7:0]};
				found = 1'b1;
			end
		end
		if (!found) begin
			give_verdict(1'b0, CAUSE_NOEDGE);
			return;
		end
		cur_step = nxt;
		if (cur_step == goal_step) begin
			give_verdict(1'b1, CAUSE_END);
			return;
		end
		bytes_seen += blen;
		if (bytes_seen > 16'hFFFF)
			bytes_seen = 16'hFFFF;
		if (bytes_seen >= max_bytes)
			give_verdict(1'b0, CAUSE_LIMIT);
	endtask

	task automatic send_item(input logic [1:0] c, input logic fc, input logic [20:0] cp,
			input logic [2:0] bl, input logic [7:0] si, input logic [3:0] sl,
			input logic [8:0] et, input logic [3:0] tot, input logic [7:0] ot,
			input logic ov);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		first_char <= fc;
		codepoint <= cp;
		byte_len <= bl;
		step_index <= si;
		slot <= sl;
		edge_target <= et;
		edge_total <= tot;
		other_target <= ot;
		other_valid <= ov;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		case (c)
			CMD_CHAR: predict_verdict(fc, cp, bl);
			CMD_EDGE: begin
				if (sl < N_EDGES) begin
					edge_cp_tab[si][sl] = cp;
					edge_to_tab[si][sl] = et;
				end
			end
			CMD_HDR: begin
				edge_cnt_tab[si] = tot;
				fallback_tab[si] = {ov, ot};
			end
			default: ;
		endcase
	endtask

	task automatic send_char(input logic fc, input logic [20:0] cp, input logic [2:0] bl);
		send_item(CMD_CHAR, fc, cp, bl, 8'($urandom), 4'($urandom), 9'($urandom),
			4'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic send_edge(input logic [7:0] s, input logic [3:0] sl,
			input logic [20:0] cp, input logic [8:0] tgt);
		send_item(CMD_EDGE, 1'($urandom), cp, 3'($urandom), s, sl, tgt, 4'($urandom),
			8'($urandom), 1'($urandom));
	endtask

	task automatic send_hdr(input logic [7:0] s, input logic [3:0] tot, input logic [7:0] ot,
			input logic ov);
		send_item(CMD_HDR, 1'($urandom), 21'($urandom), 3'($urandom), s, 4'($urandom),
			9'($urandom), tot, ot, ov);
	endtask

	// ignored beats: unused command or slot beyond the table
	task automatic send_noise();
		if ($urandom_range(1))
			send_item(CMD_UNUSED, 1'($urandom), 21'($urandom), 3'($urandom), 8'($urandom),
				4'($urandom), 9'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
		else
			send_edge(8'($urandom), 4'($urandom_range(N_EDGES, 15)), 21'($urandom),
				9'($urandom));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_STEP_COUNT)
			goal_step = val[8:0];
		else
			max_bytes = val;
	endtask

	function automatic logic [8:0] pick_target();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 9'd256;
		if (r == 1)
			return goal_step;
		return 9'($urandom_range(pat_n - 1));
	endfunction

	function automatic logic [7:0] pick_fallback();
		if ($urandom_range(5) == 0 && goal_step < N_STEPS)
			return goal_step[7:0];
		return 8'($urandom_range(pat_n - 1));
	endfunction

	function automatic logic [20:0] pick_edge_cp();
		int r;
		r = $urandom_range(19);
		if (r < 16)
			return 21'($urandom_range(1, 6));
		if (r < 19)
			return 21'($urandom);
		return '0;
	endfunction

	// every slot of each step is written, so any edge count is safe to walk
	task automatic load_pattern(input int n);
		pat_n = n;
		for (int s = 0; s < n; s++) begin
			for (int e = 0; e < N_EDGES; e++)
				send_edge(8'(s), 4'(e), pick_edge_cp(), pick_target());
			send_hdr(8'(s), 4'($urandom_range(15)), pick_fallback(), $urandom_range(3) != 0);
		end
	endtask

	function automatic logic [20:0] pick_char_cp();
		int r;
		r = $urandom_range(19);
		if (r < 13)
			return edge_cp_tab[$urandom_range(pat_n - 1)][$urandom_range(N_EDGES - 1)];
		if (r < 16)
			return 21'($urandom_range(1, 6));
		if (r < 19)
			return 21'($urandom);
		return '0;
	endfunction

	task automatic send_strings(input int n_chars);
		int left;
		int len;
		left = n_chars;
		while (left > 0) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len && left > 0; i++) begin
				send_char(i == 0, pick_char_cp(), 3'($urandom_range(7) == 0 ?
					$urandom_range(7) : $urandom_range(1, 4)));
				left--;
				if ($urandom_range(15) == 0)
					send_noise();
			end
		end
	endtask

	task automatic test_directed();
		write_reg(REG_STEP_COUNT, 16'd0);
		write_reg(REG_MAX_BYTES, 16'd0);
		send_char(1'b1, 21'd5, 3'd1);
		send_char(1'b0, 21'd0, 3'd1);
		write_reg(REG_STEP_COUNT, 16'd2);
		load_pattern(2);
		send_hdr(8'd0, 4'd15, 8'd1, 1'b1);
		send_hdr(8'd255, 4'd15, 8'hFF, 1'b1);
		send_edge(8'd255, 4'd11, 21'h1FFFFF, 9'd256);
		send_edge(8'd0, 4'd15, 21'h1FFFFF, 9'h1FF);
		send_item(CMD_UNUSED, 1'b1, 21'h1FFFFF, 3'd7, 8'hFF, 4'hF, 9'h1FF, 4'hF, 8'hFF, 1'b1);
		send_char(1'b1, 21'd0, 3'd1);
		send_char(1'b1, 21'h1FFFFF, 3'd0);
		send_char(1'b1, edge_cp_tab[0][0], 3'd7);
		send_char(1'b0, edge_cp_tab[1][0], 3'd0);
		write_reg(REG_MAX_BYTES, 16'd65535);
		send_char(1'b1, edge_cp_tab[0][1], 3'd0);
		send_char(1'b0, edge_cp_tab[1][1], 3'd7);
		send_char(1'b0, 21'h1FFFFF, 3'd4);
	endtask

	task automatic test_random_phase(input int mode, input int ph);
		logic [8:0]  sc;
		logic [15:0] mb;
		int          n;
		send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 78 : 0;
		recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 38 : 0;
		n = $urandom_range(1, 6);
		case ($urandom_range(9))
			0: sc = 9'd0;
			1: sc = 9'd256;
			2: sc = 9'd255;
			default: sc = 9'($urandom_range(1, n));
		endcase
		case ($urandom_range(7))
			0: mb = 16'd0;
			1: mb = 16'd1;
			2: mb = 16'd65535;
			3: mb = 16'd4096;
			default: mb = 16'($urandom_range(3, 30));
		endcase
		if (ph == 0) begin
			sc = 9'd256;
			mb = 16'd65535;
		end else if (ph == 1) begin
			sc = 9'd1;
			mb = 16'd1;
		end
		write_reg(REG_STEP_COUNT, {7'd0, sc});
		write_reg(REG_MAX_BYTES, mb);
		load_pattern(n);
		send_strings(30);
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cmd = CMD_CHAR;
		first_char = 1'b0;
		codepoint = '0;
		byte_len = '0;
		step_index = '0;
		slot = '0;
		edge_target = '0;
		edge_total = '0;
		other_target = '0;
		other_valid = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_STEP_COUNT;
		wr_data = '0;
		errors = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pat_n = 1;
		cur_step = '0;
		bytes_seen = 0;
		verdict_done = 1'b0;
		goal_step = 9'd0;
		max_bytes = 16'd4096;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int mode = 0; mode < 3; mode++)
			for (int ph = 0; ph < 3; ph++)
				test_random_phase(mode, ph);
		wait_idle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
